/* design/sgi_pkg.sv */
package sgi_pkg;

  // Default coordinate width in bits (signed fixed point)
  localparam int CoordWidthDefault = 32;

  // Lanes of the point divider: first x, first y, second x, second y
  localparam int NumLanes = 4;

endpackage

/* design/sgi_front.sv */
module sgi_front import sgi_pkg::*; #(
  parameter int COORD_WIDTH = CoordWidthDefault
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   adv,
  input  logic                                   in_valid,
  input  logic [8*COORD_WIDTH-1:0]               in_coords,
  output logic                                   out_valid,
  output logic [2*COORD_WIDTH+2:0]               out_den,
  output logic [NumLanes-1:0][2*COORD_WIDTH+2:0] out_rem,
  output logic [NumLanes-1:0][COORD_WIDTH+1:0]   out_lo,
  output logic [4*COORD_WIDTH+2*NumLanes+1:0]    out_side
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = 2*W + 3;
  localparam int L  = W + 2;
  localparam int QB = W + 2;
  localparam int NW = 3*W + 4;

  logic [6:0] v_r;

  // stage 1: differences
  logic signed [W:0]   px_r, py_r, ex_r, ey_r, ox_r, oy_r;
  logic [4*W-1:0]      base1_r, base2_r, base3_r, base4_r, base5_r, base6_r, base7_r;

  // stage 2: products
  logic signed [2*W+1:0] pr_r [6];
  logic signed [W:0]     m2_r [NumLanes];

  // stage 3: determinants
  logic signed [DW-1:0] den3_r, tn3_r, un3_r;
  logic signed [W:0]    m3_r [NumLanes];

  // stage 4: sign-normalized
  logic signed [DW-1:0] den4_r, tn4_r, un4_r;
  logic                 hit4_r, par4_r;
  logic signed [W:0]    m4_r [NumLanes];

  // stage 5..7
  logic signed [2*W+3:0] plo_r [NumLanes];
  logic signed [2*W+1:0] phi_r [NumLanes];
  logic signed [DW-1:0]  den5_r, den6_r, den7_r;
  logic                  hit5_r, par5_r, hit6_r, par6_r, hit7_r, par7_r;
  logic signed [NW-1:0]  num_r [NumLanes];
  logic [NumLanes-1:0][DW-1:0] rem_r;
  logic [NumLanes-1:0][QB-1:0] lo_r;
  logic [NumLanes-1:0]         neg_r, ovf_r;

  logic signed [W-1:0] ax, ay, bx, by, cx, cy, dx, dy;
  logic signed [DW-1:0] den_abs;
  logic                 den_neg;
  logic signed [DW-1:0] tn_n, un_n;

  assign ax = in_coords[0*W +: W];
  assign ay = in_coords[1*W +: W];
  assign bx = in_coords[2*W +: W];
  assign by = in_coords[3*W +: W];
  assign cx = in_coords[4*W +: W];
  assign cy = in_coords[5*W +: W];
  assign dx = in_coords[6*W +: W];
  assign dy = in_coords[7*W +: W];

  assign den_neg = den3_r[DW-1];
  assign den_abs = den_neg ? -den3_r : den3_r;
  assign tn_n    = den_neg ? -tn3_r : tn3_r;
  assign un_n    = den_neg ? -un3_r : un3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= (W+1)'(bx) - (W+1)'(ax);
      py_r <= (W+1)'(by) - (W+1)'(ay);
      ex_r <= (W+1)'(dx) - (W+1)'(cx);
      ey_r <= (W+1)'(dy) - (W+1)'(cy);
      ox_r <= (W+1)'(ax) - (W+1)'(cx);
      oy_r <= (W+1)'(ay) - (W+1)'(cy);
      base1_r <= {cy, cx, ay, ax};

      pr_r[0] <= ey_r * px_r;
      pr_r[1] <= ex_r * py_r;
      pr_r[2] <= ex_r * oy_r;
      pr_r[3] <= ey_r * ox_r;
      pr_r[4] <= oy_r * px_r;
      pr_r[5] <= ox_r * py_r;
      m2_r[0] <= px_r;
      m2_r[1] <= py_r;
      m2_r[2] <= ex_r;
      m2_r[3] <= ey_r;
      base2_r <= base1_r;

      den3_r  <= DW'(pr_r[0]) - DW'(pr_r[1]);
      tn3_r   <= DW'(pr_r[2]) - DW'(pr_r[3]);
      un3_r   <= DW'(pr_r[4]) - DW'(pr_r[5]);
      m3_r    <= m2_r;
      base3_r <= base2_r;

      den4_r  <= den_abs;
      tn4_r   <= tn_n;
      un4_r   <= un_n;
      par4_r  <= (den3_r == '0);
      hit4_r  <= (den3_r != '0) && !tn_n[DW-1] && (tn_n <= den_abs) &&
                 !un_n[DW-1] && (un_n <= den_abs);
      m4_r    <= m3_r;
      base4_r <= base3_r;

      // split each numerator factor into low (unsigned) and high (signed) parts
      for (int i = 0; i < NumLanes; i++) begin
        plo_r[i] <= m4_r[i] * $signed({1'b0, ((i < 2) ? tn4_r[L-1:0] : un4_r[L-1:0])});
        phi_r[i] <= m4_r[i] * $signed((i < 2) ? tn4_r[DW-1:L] : un4_r[DW-1:L]);
      end
      den5_r  <= den4_r;
      hit5_r  <= hit4_r;
      par5_r  <= par4_r;
      base5_r <= base4_r;

      for (int i = 0; i < NumLanes; i++) begin
        num_r[i] <= (NW'(phi_r[i]) <<< L) + NW'(plo_r[i]);
      end
      den6_r  <= den5_r;
      hit6_r  <= hit5_r;
      par6_r  <= par5_r;
      base6_r <= base5_r;

      for (int i = 0; i < NumLanes; i++) begin
        logic [NW-1:0] mag;
        logic [DW-1:0] top;
        mag = num_r[i][NW-1] ? NW'(-num_r[i]) : NW'(num_r[i]);
        top = DW'(mag[NW-1:QB]);
        neg_r[i] <= num_r[i][NW-1];
        ovf_r[i] <= (top >= den6_r);
        rem_r[i] <= (top >= den6_r) ? '0 : top;
        lo_r[i]  <= mag[QB-1:0];
      end
      den7_r  <= den6_r;
      hit7_r  <= hit6_r;
      par7_r  <= par6_r;
      base7_r <= base6_r;
    end
  end

  assign out_valid = v_r[6];
  assign out_den   = den7_r;
  assign out_rem   = rem_r;
  assign out_lo    = lo_r;
  assign out_side  = {ovf_r, neg_r, par7_r, hit7_r, base7_r};

endmodule

/* design/sgi_div_cell.sv */
module sgi_div_cell import sgi_pkg::*; #(
  parameter int COORD_WIDTH = CoordWidthDefault
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   adv,
  input  logic                                   in_valid,
  input  logic [2*COORD_WIDTH+2:0]               in_den,
  input  logic [NumLanes-1:0][2*COORD_WIDTH+2:0] in_rem,
  input  logic [NumLanes-1:0][COORD_WIDTH+1:0]   in_lo,
  input  logic [NumLanes-1:0][COORD_WIDTH+1:0]   in_q,
  input  logic [4*COORD_WIDTH+2*NumLanes+1:0]    in_side,
  output logic                                   out_valid,
  output logic [2*COORD_WIDTH+2:0]               out_den,
  output logic [NumLanes-1:0][2*COORD_WIDTH+2:0] out_rem,
  output logic [NumLanes-1:0][COORD_WIDTH+1:0]   out_lo,
  output logic [NumLanes-1:0][COORD_WIDTH+1:0]   out_q,
  output logic [4*COORD_WIDTH+2*NumLanes+1:0]    out_side
);

  localparam int DW = 2*COORD_WIDTH + 3;
  localparam int QB = COORD_WIDTH + 2;

  logic                        valid_r;
  logic [DW-1:0]               den_r;
  logic [NumLanes-1:0][DW-1:0] rem_r, rem_nxt;
  logic [NumLanes-1:0][QB-1:0] lo_r, q_r, q_nxt;
  logic [4*COORD_WIDTH+2*NumLanes+1:0] side_r;

  // one restoring step per lane: shift in next dividend bit, subtract if it fits
  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      logic [DW:0] t;
      logic        ge;
      t  = {in_rem[i], in_lo[i][QB-1]};
      ge = (t >= {1'b0, in_den});
      rem_nxt[i] = ge ? DW'(t - {1'b0, in_den}) : t[DW-1:0];
      q_nxt[i]   = {in_q[i][QB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r  <= in_den;
      rem_r  <= rem_nxt;
      side_r <= in_side;
      q_r    <= q_nxt;
      for (int i = 0; i < NumLanes; i++) begin
        lo_r[i] <= {in_lo[i][QB-2:0], 1'b0};
      end
    end
  end

  assign out_valid = valid_r;
  assign out_den   = den_r;
  assign out_rem   = rem_r;
  assign out_lo    = lo_r;
  assign out_q     = q_r;
  assign out_side  = side_r;

endmodule

/* design/segment_intersection_2d_unit.sv */
// Pipeline: seven front stages, COORD_WIDTH + 2 divider cells and an output register
// lie between an accepted request and its offered result.
// Throughput: one request per cycle; the whole pipe holds while the output
// register is full and not taken, so in_tready is low only then.
// Latency is dominated by the row of COORD_WIDTH + 2 divider cells, one quotient bit each.
// Reset (rst_n low, synchronous) empties every pipeline stage and the output register.
module segment_intersection_2d_unit import sgi_pkg::*; #(
  parameter int COORD_WIDTH = CoordWidthDefault
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y (COORD_WIDTH each, signed), zero fill
  input  logic [((8*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // hit, parallel, first_x, first_y, second_x, second_y (coords signed), zero fill
  output logic [((4*COORD_WIDTH+2+7)/8)*8-1:0] out_tdata
);

  localparam int W   = COORD_WIDTH;
  localparam int DW  = 2*W + 3;
  localparam int QB  = W + 2;
  localparam int SW  = 4*W + 2*NumLanes + 2;
  localparam int OTW = ((4*W+2+7)/8)*8;

  logic out_valid_r;
  logic [OTW-1:0] out_data_r, out_data_nxt;

  // Global advance: move every stage when the output slot is free or being taken.
  logic adv;
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // Chain links: index k feeds divider cell k
  logic [QB:0]                           ch_valid;
  logic [QB:0][DW-1:0]                   ch_den;
  logic [QB:0][NumLanes-1:0][DW-1:0]     ch_rem;
  logic [QB:0][NumLanes-1:0][QB-1:0]     ch_lo;
  logic [QB:0][NumLanes-1:0][QB-1:0]     ch_q;
  logic [QB:0][SW-1:0]                   ch_side;

  sgi_front #(.COORD_WIDTH(W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_tvalid),
    .in_coords (in_tdata[8*W-1:0]),
    .out_valid (ch_valid[0]),
    .out_den   (ch_den[0]),
    .out_rem   (ch_rem[0]),
    .out_lo    (ch_lo[0]),
    .out_side  (ch_side[0])
  );

  assign ch_q[0] = '0;

  // Row of restoring-division cells, one quotient bit per cell
  for (genvar k = 0; k < QB; k++) begin : g_cell
    sgi_div_cell #(.COORD_WIDTH(W)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (ch_valid[k]),
      .in_den    (ch_den[k]),
      .in_rem    (ch_rem[k]),
      .in_lo     (ch_lo[k]),
      .in_q      (ch_q[k]),
      .in_side   (ch_side[k]),
      .out_valid (ch_valid[k+1]),
      .out_den   (ch_den[k+1]),
      .out_rem   (ch_rem[k+1]),
      .out_lo    (ch_lo[k+1]),
      .out_q     (ch_q[k+1]),
      .out_side  (ch_side[k+1])
    );
  end

  // Unpack side data from the end of the row
  logic [SW-1:0]       side;
  logic                hit, par;
  logic [NumLanes-1:0] neg, ovf;
  assign side = ch_side[QB];
  assign hit  = side[4*W];
  assign par  = side[4*W+1];
  assign neg  = side[4*W+2 +: NumLanes];
  assign ovf  = side[4*W+2+NumLanes +: NumLanes];

  // Apply sign, add start point, saturate to the coordinate range
  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[0] = hit && !par;
    out_data_nxt[1] = par;
    for (int i = 0; i < NumLanes; i++) begin
      logic signed [W+2:0] qs;
      logic signed [W+3:0] sum;
      logic signed [W-1:0] pt;
      qs  = neg[i] ? -$signed({1'b0, ch_q[QB][i]}) : $signed({1'b0, ch_q[QB][i]});
      sum = (W+4)'($signed(side[i*W +: W])) + (W+4)'(qs);
      if (ovf[i]) begin
        pt = neg[i] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else if (sum > (W+4)'($signed({1'b0, {(W-1){1'b1}}}))) begin
        pt = {1'b0, {(W-1){1'b1}}};
      end else if (sum < (W+4)'($signed({1'b1, {(W-1){1'b0}}}))) begin
        pt = {1'b1, {(W-1){1'b0}}};
      end else begin
        pt = sum[W-1:0];
      end
      // drop points when the lines are parallel
      out_data_nxt[2+i*W +: W] = par ? '0 : pt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ch_valid[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* bench/segment_intersection_2d_unit_tb.sv */
`timescale 1ns / 100ps

module segment_intersection_2d_unit_tb;
  import sgi_pkg::*;

  localparam int CW = CoordWidthDefault;
  localparam int IN_W = ((8*CW+7)/8)*8;
  localparam int OUT_W = ((4*CW+2+7)/8)*8;
  localparam int NUM_RANDOM = 1700;
  // last stretch of requests runs with no idling on either side
  localparam int QUIET_TAIL = 200;
  // extra wait once every expected result has arrived
  localparam int DRAIN_CYCLES = 80;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [CW-1:0] coord_t;

  // Exact intersection of segment AB with segment CD, packed as out_tdata.
  function automatic logic [OUT_W-1:0] intersect_segments(logic [IN_W-1:0] req);
    wide_t ax, ay, bx, by, cx, cy, dx, dy;
    wide_t px, py, ex, ey, ox, oy, den, tn, un;
    wide_t pt[4];
    wide_t hi, lo;
    logic [OUT_W-1:0] res;
    logic hit;
    hi = (wide_t'(1) <<< (CW-1)) - wide_t'(1);
    lo = -(wide_t'(1) <<< (CW-1));
    ax = $signed(req[0*CW +: CW]);
    ay = $signed(req[1*CW +: CW]);
    bx = $signed(req[2*CW +: CW]);
    by = $signed(req[3*CW +: CW]);
    cx = $signed(req[4*CW +: CW]);
    cy = $signed(req[5*CW +: CW]);
    dx = $signed(req[6*CW +: CW]);
    dy = $signed(req[7*CW +: CW]);
    px = bx - ax; py = by - ay;
    ex = dx - cx; ey = dy - cy;
    ox = ax - cx; oy = ay - cy;
    den = ey*px - ex*py;
    res = '0;
    if (den == 0) begin
      res[1] = 1'b1;
      return res;
    end
    tn = ex*oy - ey*ox;
    un = oy*px - ox*py;
    if (den < 0) begin
      den = -den; tn = -tn; un = -un;
    end
    hit = tn >= 0 && tn <= den && un >= 0 && un <= den;
    // division truncates toward zero, then add the start point
    pt[0] = ax + (px*tn)/den;
    pt[1] = ay + (py*tn)/den;
    pt[2] = cx + (ex*un)/den;
    pt[3] = cy + (ey*un)/den;
    res[0] = hit;
    for (int i = 0; i < 4; i++) begin
      if (pt[i] > hi) pt[i] = hi;
      else if (pt[i] < lo) pt[i] = lo;
      res[2 + i*CW +: CW] = pt[i][CW-1:0];
    end
    return res;
  endfunction

  class intersect_scoreboard;
    logic [OUT_W-1:0] expected_q[$];
    int mismatches;

    function void note_request(logic [IN_W-1:0] req);
      expected_q.push_back(intersect_segments(req));
    endfunction

    function void check_result(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      string names[6];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no request pending: %h", got);
        return;
      end
      want = expected_q.pop_front();
      names = '{"first_x", "first_y", "second_x", "second_y", "hit", "parallel"};
      for (int f = 0; f < 6; f++) begin
        logic [CW-1:0] w, g;
        if (f < 4) begin
          w = want[2 + f*CW +: CW]; g = got[2 + f*CW +: CW];
        end else begin
          w = CW'(want[f-4]); g = CW'(got[f-4]);
        end
        if (w !== g) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%s mismatch: expected %h, got %h", names[f], w, g);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;

  intersect_scoreboard sb;
  int sent;
  bit quiet;
  bit stim_done;

  segment_intersection_2d_unit #(.COORD_WIDTH(CW)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Pack eight coordinates A, B, C, D (x then y) into one request word.
  function automatic logic [IN_W-1:0] pack_segments(coord_t c[8]);
    logic [IN_W-1:0] w;
    w = '0;
    for (int i = 0; i < 8; i++) w[i*CW +: CW] = c[i];
    return w;
  endfunction

  // Offer one request, hold until taken, then maybe idle for a burst.
  task automatic send_request(coord_t c[8]);
    in_tdata <= pack_segments(c);
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_request(pack_segments(c));
    sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  function automatic coord_t small_coord();
    return coord_t'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
  endfunction

  function automatic coord_t edge_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'(32'h7fffffff);
      1: return coord_t'(32'h80000000);
      2: return '0;
      3: return coord_t'(-1);
      4: return coord_t'(1);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Build a random pair of segments, mostly well-formed geometry.
  task automatic random_pair(output coord_t c[8]);
    int kind;
    int k;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 8; i++) c[i] = small_coord();
    if (kind < 15) begin
      for (int i = 0; i < 8; i++) c[i] = coord_t'($urandom);
    end else if (kind < 25) begin
      // CD parallel to AB: D = C + k*(B - A)
      k = $signed($urandom_range(0, 6)) - 3;
      c[6] = c[4] + k*(c[2] - c[0]);
      c[7] = c[5] + k*(c[3] - c[1]);
    end else if (kind < 33) begin
      // shared endpoint: touching at t or u equal to 0 or 1
      if ($urandom_range(0, 1)) begin
        c[4] = c[2]; c[5] = c[3];
      end else begin
        c[6] = c[0]; c[7] = c[1];
      end
    end else if (kind < 45) begin
      for (int i = 0; i < 8; i++) c[i] = edge_coord();
    end else if (kind < 50) begin
      // degenerate first segment
      c[2] = c[0]; c[3] = c[1];
    end else if (kind < 55) begin
      // tiny segments, near the rounding limit
      for (int i = 0; i < 8; i++) c[i] = coord_t'($signed($urandom_range(0, 8)) - 4);
    end
  endtask

  initial begin
    coord_t c[8];
    coord_t mx, mn;
    sb = new();
    sent = 0;
    quiet = 1'b0;
    stim_done = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    mx = coord_t'(32'h7fffffff);
    mn = coord_t'(32'h80000000);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: all zero, i.e. fully degenerate and parallel
    c = '{default: '0}; send_request(c);
    // plain cross through the origin
    c = '{-(1<<16), 0, (1<<16), 0, 0, -(1<<16), 0, (1<<16)}; send_request(c);
    // cross outside both segments
    c = '{(2<<16), 0, (3<<16), 0, 0, (2<<16), 0, (3<<16)}; send_request(c);
    // touch at t = 0 and u = 1
    c = '{0, 0, (1<<16), (1<<16), (1<<16), 0, 0, 0}; send_request(c);
    // touch at t = 1 and u = 0
    c = '{0, 0, (1<<16), 0, (1<<16), 0, (1<<16), (1<<16)}; send_request(c);
    // collinear overlap
    c = '{0, 0, (2<<16), (2<<16), (1<<16), (1<<16), (3<<16), (3<<16)}; send_request(c);
    // parallel, apart
    c = '{0, 0, (1<<16), 0, 0, (1<<16), (1<<16), (1<<16)}; send_request(c);
    // coordinates at the extremes
    c = '{mn, mn, mx, mx, mn, mx, mx, mn}; send_request(c);
    c = '{mx, mx, mn, mn, mx, mn, mn, mx}; send_request(c);
    // saturating point: near-parallel long lines meeting far away
    c = '{mn, 0, mx, 1, mn, 3, mx, 2}; send_request(c);
    c = '{mn, mn, mx, mn + 1, mn, mn + 2, mx, mn + 2}; send_request(c);
    // negative rounding toward zero
    c = '{0, 0, 3, 1, 1, -2, 0, 2}; send_request(c);
    c = '{-3, 0, 0, -7, -1, 5, -2, -6}; send_request(c);
    // all ones and single bits
    c = '{default: coord_t'(-1)}; send_request(c);
    c = '{1, 2, 4, 8, 16, 32, 64, 128}; send_request(c);
    c = '{mx, 0, 0, mx, mn, 0, 0, mn}; send_request(c);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n >= NUM_RANDOM - QUIET_TAIL) quiet = 1'b1;
      random_pair(c);
      send_request(c);
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;

    // drain: wait for every expected result, then a little longer
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("segment_intersection_2d_unit_tb: clean");
    end else begin
      $display("segment_intersection_2d_unit_tb: errors");
    end
    $finish;
  end

  // Result side: check each accepted result, stall in bursts, and once
  // hold off long enough that the pipe fills and in_tready drops.
  initial begin
    int stall;
    int hold_left;
    bit pressure_done;
    stall = 0;
    hold_left = 0;
    pressure_done = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
      if (!pressure_done && sent >= 300) begin
        pressure_done = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else if (!quiet && !stim_done && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 11) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(12 * 400000);
    $display("segment_intersection_2d_unit_tb: errors");
    $finish;
  end

endmodule

/* segment_intersection_2d_unit.f */
design/sgi_pkg.sv
design/sgi_front.sv
design/sgi_div_cell.sv
design/segment_intersection_2d_unit.sv
bench/segment_intersection_2d_unit_tb.sv
